[hdl/rerm_pkg.sv]
// rerm_pkg: shared types, reset constants and helper functions for the
// Raft election role machine. No dependencies.
package rerm_pkg;

  localparam int unsigned MAX_NODES_DEF = 16;
  localparam int unsigned TERM_BITS_DEF = 32;

  localparam int unsigned TERM_W  = 32;   // width of term fields on the ports
  localparam int unsigned CNT_W   = 16;
  localparam int unsigned VOTES_W = 5;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [3:0]         RST_NODE_ID      = 4'd0;
  localparam logic [4:0]         RST_CLUSTER_SIZE = 5'd3;
  localparam logic [CNT_W-1:0]   RST_TIMEOUT_MIN  = 16'd150;
  localparam logic [CNT_W-1:0]   RST_RANGE_MASK   = 16'd127;
  localparam logic [CNT_W-1:0]   RST_HB_PERIOD    = 16'd50;
  localparam logic [CNT_W-1:0]   RST_SEED         = 16'd1;

  localparam logic [CNT_W-1:0]   CNT_MAX   = 16'hFFFF;
  localparam logic [VOTES_W-1:0] VOTES_MAX = 5'd31;
  localparam logic [CNT_W-1:0]   LFSR_TAPS = 16'hB400;

  typedef enum logic [1:0] {
    ROLE_FOLLOWER  = 2'd0,
    ROLE_CANDIDATE = 2'd1,
    ROLE_LEADER    = 2'd2
  } role_e;

  typedef enum logic [1:0] {
    OP_TICK       = 2'd0,
    OP_VOTE_REQ   = 2'd1,
    OP_VOTE_REPLY = 2'd2,
    OP_APPEND     = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NODE_ID      = 3'd0,
    CFG_CLUSTER_SIZE = 3'd1,
    CFG_TIMEOUT_MIN  = 3'd2,
    CFG_RANGE_MASK   = 3'd3,
    CFG_HB_PERIOD    = 3'd4,
    CFG_RANDOM_SEED  = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [3:0]       node_id;
    logic [4:0]       cluster_size;
    logic [CNT_W-1:0] timeout_min;
    logic [CNT_W-1:0] range_mask;
    logic [CNT_W-1:0] hb_period;
  } cfg_t;

  typedef struct packed {
    logic [1:0]        op;
    logic [TERM_W-1:0] msg_term;
    logic [3:0]        candidate;
    logic              vote_given;
    logic [TERM_W-1:0] asked_term;
  } in_item_t;

  typedef struct packed {
    role_e             role;
    logic [TERM_W-1:0] term_now;
    logic [TERM_W-1:0] reply_term;
    logic              granted;
    logic              start_election;
    logic              send_heartbeats;
  } result_t;

  // Galois LFSR, one shift
  function automatic logic [CNT_W-1:0] lfsr_step(input logic [CNT_W-1:0] cur);
    logic [CNT_W-1:0] nxt;
    nxt = cur >> 1;
    if (cur[0]) begin
      nxt = nxt ^ LFSR_TAPS;
    end
    return nxt;
  endfunction

  // timeout_min + masked random, saturated to 16 bits
  function automatic logic [CNT_W-1:0] timeout_draw(input logic [CNT_W-1:0] rnd,
                                                    input logic [CNT_W-1:0] tmin,
                                                    input logic [CNT_W-1:0] mask);
    logic [CNT_W:0] sum;
    sum = {1'b0, tmin} + {1'b0, rnd & mask};
    return sum[CNT_W] ? CNT_MAX : sum[CNT_W-1:0];
  endfunction

endpackage

[hdl/rerm_cfg.sv]
// rerm_cfg: configuration register file of the election role machine.
// Depends on rerm_pkg.
module rerm_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                wr_en_i,
  input  logic [rerm_pkg::CFG_IDX_W-1:0]      wr_idx_i,
  input  logic [rerm_pkg::CFG_DATA_W-1:0]     wr_data_i,
  output rerm_pkg::cfg_t                      cfg_o
);

  rerm_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.node_id      <= rerm_pkg::RST_NODE_ID;
      cfg_q.cluster_size <= rerm_pkg::RST_CLUSTER_SIZE;
      cfg_q.timeout_min  <= rerm_pkg::RST_TIMEOUT_MIN;
      cfg_q.range_mask   <= rerm_pkg::RST_RANGE_MASK;
      cfg_q.hb_period    <= rerm_pkg::RST_HB_PERIOD;
    end else if (wr_en_i) begin
      unique case (rerm_pkg::cfg_idx_e'(wr_idx_i))
        rerm_pkg::CFG_NODE_ID:      cfg_q.node_id      <= wr_data_i[3:0];
        rerm_pkg::CFG_CLUSTER_SIZE: cfg_q.cluster_size <= wr_data_i[4:0];
        rerm_pkg::CFG_TIMEOUT_MIN:  cfg_q.timeout_min  <= wr_data_i;
        rerm_pkg::CFG_RANGE_MASK:   cfg_q.range_mask   <= wr_data_i;
        rerm_pkg::CFG_HB_PERIOD:    cfg_q.hb_period    <= wr_data_i;
        // seed only matters at reset, where the default is loaded
        rerm_pkg::CFG_RANDOM_SEED:  ;
        default:                    ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

[hdl/rerm_core.sv]
// rerm_core: role, term, vote and timer state plus the single-pass step logic.
// Depends on rerm_pkg.
module rerm_core #(
  parameter int unsigned MAX_NODES = rerm_pkg::MAX_NODES_DEF,
  parameter int unsigned TERM_BITS = rerm_pkg::TERM_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  rerm_pkg::in_item_t item_i,
  input  rerm_pkg::cfg_t     cfg_i,
  output rerm_pkg::result_t  res_o
);

  localparam int unsigned CW = rerm_pkg::CNT_W;
  localparam int unsigned VW = rerm_pkg::VOTES_W;
  localparam int unsigned TW = rerm_pkg::TERM_W;
  localparam int unsigned WB = (TERM_BITS > TW) ? TERM_BITS : TW;

  rerm_pkg::role_e        role_q, role_d;
  logic [TERM_BITS-1:0]   term_q, term_d;
  logic [3:0]             vote_target_q, vote_target_d;
  logic                   has_voted_q, has_voted_d;
  logic [VW-1:0]          votes_q, votes_d;
  logic [CW-1:0]          heard_q, heard_d;
  logic [CW-1:0]          sent_q, sent_d;
  logic [CW-1:0]          timeout_q, timeout_d;
  logic [CW-1:0]          lfsr_q, lfsr_d;

  logic [WB-1:0]          msg_ext, asked_ext, term_ext, reply_ext;
  logic [TERM_BITS-1:0]   t, asked, reply_term;
  logic [6:0]             size_ext, size_clamp;
  logic [5:0]             majority;
  logic [CW-1:0]          heard_inc, sent_inc, lfsr_cur, lfsr_nxt;
  logic                   granted, start, beats;

  assign msg_ext   = WB'(item_i.msg_term);
  assign asked_ext = WB'(item_i.asked_term);
  assign t         = msg_ext[TERM_BITS-1:0];
  assign asked     = asked_ext[TERM_BITS-1:0];

  // majority of the cluster, size clamped to MAX_NODES
  assign size_ext   = 7'(cfg_i.cluster_size);
  assign size_clamp = (size_ext > 7'(MAX_NODES)) ? 7'(MAX_NODES) : size_ext;
  assign majority   = size_clamp[6:1] + 6'd1;

  assign heard_inc = (heard_q == rerm_pkg::CNT_MAX) ? heard_q : heard_q + 1'b1;
  assign sent_inc  = (sent_q  == rerm_pkg::CNT_MAX) ? sent_q  : sent_q + 1'b1;
  assign lfsr_cur  = (lfsr_q == '0) ? rerm_pkg::RST_SEED : lfsr_q;
  assign lfsr_nxt  = rerm_pkg::lfsr_step(lfsr_cur);

  always_comb begin
    role_d        = role_q;
    term_d        = term_q;
    vote_target_d = vote_target_q;
    has_voted_d   = has_voted_q;
    votes_d       = votes_q;
    heard_d       = heard_q;
    sent_d        = sent_q;
    timeout_d     = timeout_q;
    lfsr_d        = lfsr_cur;
    reply_term    = '0;
    granted       = 1'b0;
    start         = 1'b0;
    beats         = 1'b0;

    unique case (rerm_pkg::op_e'(item_i.op))
      rerm_pkg::OP_TICK: begin
        heard_d = heard_inc;
        sent_d  = sent_inc;
        if (role_q != rerm_pkg::ROLE_LEADER && heard_inc >= timeout_q) begin
          role_d        = rerm_pkg::ROLE_CANDIDATE;
          term_d        = term_q + 1'b1;
          vote_target_d = cfg_i.node_id;
          has_voted_d   = 1'b1;
          votes_d       = VW'(1);
          heard_d       = '0;
          start         = 1'b1;
          lfsr_d        = lfsr_nxt;
          timeout_d     = rerm_pkg::timeout_draw(lfsr_nxt, cfg_i.timeout_min,
                                                 cfg_i.range_mask);
          // single-node cluster: own vote is already a majority
          if (majority <= 6'd1) begin
            role_d = rerm_pkg::ROLE_LEADER;
            beats  = 1'b1;
          end
        end else if (role_q == rerm_pkg::ROLE_LEADER && sent_inc >= cfg_i.hb_period) begin
          beats  = 1'b1;
          sent_d = '0;
        end
      end
      rerm_pkg::OP_VOTE_REQ: begin
        if (t >= term_q) begin
          if (t > term_q) begin
            role_d      = rerm_pkg::ROLE_FOLLOWER;
            term_d      = t;
            has_voted_d = 1'b0;
          end
          if (!has_voted_d || vote_target_q == item_i.candidate) begin
            vote_target_d = item_i.candidate;
            has_voted_d   = 1'b1;
            heard_d       = '0;
            granted       = 1'b1;
          end
        end
        reply_term = term_d;
      end
      rerm_pkg::OP_VOTE_REPLY: begin
        if (role_q == rerm_pkg::ROLE_CANDIDATE && asked == term_q) begin
          if (t > term_q) begin
            role_d      = rerm_pkg::ROLE_FOLLOWER;
            term_d      = t;
            has_voted_d = 1'b0;
          end else if (item_i.vote_given) begin
            if (votes_q < rerm_pkg::VOTES_MAX) begin
              votes_d = votes_q + 1'b1;
            end
            if (6'(votes_d) >= majority) begin
              role_d = rerm_pkg::ROLE_LEADER;
              beats  = 1'b1;
            end
          end
        end
      end
      rerm_pkg::OP_APPEND: begin
        if (t >= term_q) begin
          role_d = rerm_pkg::ROLE_FOLLOWER;
          if (t > term_q) begin
            term_d      = t;
            has_voted_d = 1'b0;
          end
          heard_d = '0;
          granted = 1'b1;
        end
        reply_term = term_d;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      role_q        <= rerm_pkg::ROLE_FOLLOWER;
      term_q        <= '0;
      vote_target_q <= '0;
      has_voted_q   <= 1'b0;
      votes_q       <= '0;
      heard_q       <= '0;
      sent_q        <= '0;
      timeout_q     <= rerm_pkg::RST_TIMEOUT_MIN;
      lfsr_q        <= rerm_pkg::RST_SEED;
    end else if (step_i) begin
      role_q        <= role_d;
      term_q        <= term_d;
      vote_target_q <= vote_target_d;
      has_voted_q   <= has_voted_d;
      votes_q       <= votes_d;
      heard_q       <= heard_d;
      sent_q        <= sent_d;
      timeout_q     <= timeout_d;
      lfsr_q        <= lfsr_d;
    end
  end

  assign term_ext  = WB'(term_d);
  assign reply_ext = WB'(reply_term);

  always_comb begin
    res_o.role            = role_d;
    res_o.term_now        = term_ext[TW-1:0];
    res_o.reply_term      = reply_ext[TW-1:0];
    res_o.granted         = granted;
    res_o.start_election  = start;
    res_o.send_heartbeats = beats;
  end

endmodule

[hdl/raft_election_role_machine.sv]
// Raft election role machine, top level: input word register, step logic,
// result register. Each accepted word passes from the input word register
// into the result register. Throughput: one word per cycle while the output
// is not stalled; the state update of one word is ready for the next word in
// the next cycle. Reset (async, active low) puts the node in follower role,
// term 0, timeout at its least value, and loads the default configuration.
module raft_election_role_machine #(
  parameter int unsigned MAX_NODES = rerm_pkg::MAX_NODES_DEF,
  parameter int unsigned TERM_BITS = rerm_pkg::TERM_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        op_i,
  input  logic [rerm_pkg::TERM_W-1:0]       msg_term_i,
  input  logic [3:0]                        candidate_i,
  input  logic                              vote_given_i,
  input  logic [rerm_pkg::TERM_W-1:0]       asked_term_i,
  // result channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [1:0]                        role_o,
  output logic [rerm_pkg::TERM_W-1:0]       term_now_o,
  output logic [rerm_pkg::TERM_W-1:0]       reply_term_o,
  output logic                              granted_o,
  output logic                              start_election_o,
  output logic                              send_heartbeats_o,
  // configuration write channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [rerm_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [rerm_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  rerm_pkg::cfg_t     cfg;
  rerm_pkg::in_item_t in_item_q, in_item_d;
  rerm_pkg::result_t  res, res_q;
  logic               in_valid_q, in_valid_d;
  logic               out_valid_q, out_valid_d;
  logic               out_hold, step, accept;

  assign cfg_ready_o = 1'b1;

  rerm_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_valid_i),
    .wr_idx_i  (cfg_index_i),
    .wr_data_i (cfg_data_i),
    .cfg_o     (cfg)
  );

  // result register blocked by the sink
  assign out_hold   = out_valid_q && out_stall_i;
  assign step       = in_valid_q && !out_hold;
  assign in_stall_o = in_valid_q && out_hold;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    in_item_d.op         = op_i;
    in_item_d.msg_term   = msg_term_i;
    in_item_d.candidate  = candidate_i;
    in_item_d.vote_given = vote_given_i;
    in_item_d.asked_term = asked_term_i;
  end

  assign in_valid_d  = accept || (in_valid_q && !step);
  assign out_valid_d = step || out_hold;

  rerm_core #(
    .MAX_NODES (MAX_NODES),
    .TERM_BITS (TERM_BITS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (in_item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      in_item_q   <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (accept) begin
        in_item_q <= in_item_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign role_o            = res_q.role;
  assign term_now_o        = res_q.term_now;
  assign reply_term_o      = res_q.reply_term;
  assign granted_o         = res_q.granted;
  assign start_election_o  = res_q.start_election;
  assign send_heartbeats_o = res_q.send_heartbeats;

  // an election start never leaves the node a follower
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && start_election_o |-> role_o != rerm_pkg::ROLE_FOLLOWER)
    else $error("election started but role is follower");

  // a granted request always replies with the current term
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && granted_o |-> reply_term_o == term_now_o)
    else $error("granted reply carries a term other than the current one");

  // input back pressure only comes from a stalled full result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back pressure");

  // a step always lands a word in the result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_valid_o)
    else $error("step lost its result word");

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// tb: self-checking bench for raft_election_role_machine, with a clocked driver, a monitor
// and an in-bench role predictor. Depends on rerm_pkg and the top-level RTL only.
module tb;
  import rerm_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd7;

  typedef enum int unsigned {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  logic clk = 1'b0;
  logic rst_n;

  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_word = '0;
  logic in_taken = 1'b0;

  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] role_o;
  logic [TERM_W-1:0] term_now_o;
  logic [TERM_W-1:0] reply_term_o;
  logic granted_o;
  logic start_election_o;
  logic send_heartbeats_o;

  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // predictor copy of the configuration
  logic [3:0] c_node_id = RST_NODE_ID;
  logic [4:0] c_size = RST_CLUSTER_SIZE;
  logic [CNT_W-1:0] c_tmin = RST_TIMEOUT_MIN;
  logic [CNT_W-1:0] c_mask = RST_RANGE_MASK;
  logic [CNT_W-1:0] c_hb = RST_HB_PERIOD;
  logic [CNT_W-1:0] c_seed = RST_SEED;

  // predictor copy of the node state
  role_e p_role = ROLE_FOLLOWER;
  logic [TERM_W-1:0] p_term = '0;
  logic [3:0] p_vote_for = '0;
  logic p_voted = 1'b0;
  logic [VOTES_W-1:0] p_tally = '0;
  logic [CNT_W-1:0] p_heard = '0;
  logic [CNT_W-1:0] p_sent = '0;
  logic [CNT_W-1:0] p_tmo = RST_TIMEOUT_MIN;
  logic [CNT_W-1:0] p_lfsr = RST_SEED;

  in_item_t pending_words[$];
  result_t pending_results[$];
  result_t exp_res;
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  always #5 clk = ~clk;

  raft_election_role_machine u_top (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .op_i             (in_word.op),
    .msg_term_i       (in_word.msg_term),
    .candidate_i      (in_word.candidate),
    .vote_given_i     (in_word.vote_given),
    .asked_term_i     (in_word.asked_term),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .role_o           (role_o),
    .term_now_o       (term_now_o),
    .reply_term_o     (reply_term_o),
    .granted_o        (granted_o),
    .start_election_o (start_election_o),
    .send_heartbeats_o(send_heartbeats_o),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data)
  );

  function automatic logic [VOTES_W-1:0] quorum();
    logic [VOTES_W-1:0] n;
    n = (c_size > MAX_NODES_DEF) ? VOTES_W'(MAX_NODES_DEF) : c_size;
    return (n >> 1) + VOTES_W'(1);
  endfunction

  function automatic void step_down(input logic [TERM_W-1:0] t);
    p_role = ROLE_FOLLOWER;
    if (t > p_term) begin
      p_term = t;
      p_voted = 1'b0;
    end
  endfunction

  // advances the predicted node by one word and returns its result word
  function automatic result_t election_step(input in_item_t w);
    result_t r;
    logic [CNT_W-1:0] nxt;
    logic [CNT_W:0] sum;
    r = '0;
    if (p_lfsr == '0) p_lfsr = CNT_W'(1);
    case (op_e'(w.op))
      OP_TICK: begin
        if (p_heard != CNT_MAX) p_heard = p_heard + 1'b1;
        if (p_sent != CNT_MAX) p_sent = p_sent + 1'b1;
        if (p_role != ROLE_LEADER && p_heard >= p_tmo) begin
          p_role = ROLE_CANDIDATE;
          p_term = p_term + 1'b1;
          p_vote_for = c_node_id;
          p_voted = 1'b1;
          p_tally = VOTES_W'(1);
          p_heard = '0;
          r.start_election = 1'b1;
          nxt = p_lfsr >> 1;
          if (p_lfsr[0]) nxt = nxt ^ LFSR_TAPS;
          p_lfsr = nxt;
          sum = {1'b0, c_tmin} + {1'b0, p_lfsr & c_mask};
          p_tmo = sum[CNT_W] ? CNT_MAX : sum[CNT_W-1:0];
          // own vote may already be a majority
          if (p_tally >= quorum()) begin
            p_role = ROLE_LEADER;
            r.send_heartbeats = 1'b1;
          end
        end else if (p_role == ROLE_LEADER && p_sent >= c_hb) begin
          r.send_heartbeats = 1'b1;
          p_sent = '0;
        end
      end
      OP_VOTE_REQ: begin
        if (w.msg_term >= p_term) begin
          if (w.msg_term > p_term) step_down(w.msg_term);
          if (!p_voted || p_vote_for == w.candidate) begin
            p_vote_for = w.candidate;
            p_voted = 1'b1;
            p_heard = '0;
            r.granted = 1'b1;
          end
        end
        r.reply_term = p_term;
      end
      OP_VOTE_REPLY: begin
        if (p_role == ROLE_CANDIDATE && w.asked_term == p_term) begin
          if (w.msg_term > p_term) begin
            step_down(w.msg_term);
          end else if (w.vote_given) begin
            if (p_tally != VOTES_MAX) p_tally = p_tally + 1'b1;
            if (p_tally >= quorum()) begin
              p_role = ROLE_LEADER;
              r.send_heartbeats = 1'b1;
            end
          end
        end
      end
      default: begin
        if (w.msg_term >= p_term) begin
          step_down(w.msg_term);
          p_heard = '0;
          r.granted = 1'b1;
        end
        r.reply_term = p_term;
      end
    endcase
    r.role = p_role;
    r.term_now = p_term;
    return r;
  endfunction

  // terms clustered around the node's term, with some far-off and extreme ones
  function automatic logic [TERM_W-1:0] pick_term(input logic [TERM_W-1:0] base);
    int unsigned k;
    k = $urandom_range(99);
    if (k < 45) return base;
    else if (k < 65) return base + 1;
    else if (k < 75) return base - 1;
    else if (k < 85) return base + TERM_W'($urandom_range(9, 2));
    else if (k < 92) return TERM_W'($urandom);
    else if (k < 96) return '0;
    else return '1;
  endfunction

  function automatic in_item_t random_word(input int unsigned tick_pct);
    in_item_t w;
    int unsigned k;
    int unsigned rest;
    w = '0;
    k = $urandom_range(99);
    rest = 100 - tick_pct;
    if (k < tick_pct) w.op = OP_TICK;
    else if (k < tick_pct + rest / 2) w.op = OP_VOTE_REPLY;
    else if (k < tick_pct + 3 * rest / 4) w.op = OP_VOTE_REQ;
    else w.op = OP_APPEND;
    w.msg_term = pick_term(p_term);
    w.asked_term = ($urandom_range(99) < 85) ? p_term : pick_term(p_term);
    w.candidate = ($urandom_range(99) < 40) ? p_vote_for : 4'($urandom_range(15));
    w.vote_given = ($urandom_range(99) < 75);
    return w;
  endfunction

  task automatic queue_word(input op_e op, input logic [TERM_W-1:0] term,
                            input logic [3:0] cand, input logic given,
                            input logic [TERM_W-1:0] asked);
    in_item_t w;
    w.op = op;
    w.msg_term = term;
    w.candidate = cand;
    w.vote_given = given;
    w.asked_term = asked;
    pending_words = {pending_words, w};
  endtask

  task automatic run_random(input int unsigned n, input int unsigned tick_pct);
    repeat (n) begin
      while (pending_words.size() >= 2) @(negedge clk);
      pending_words = {pending_words, random_word(tick_pct)};
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (pending_words.size() != 0 || in_valid || pending_results.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_config(input logic [15:0] node, input logic [15:0] size,
                             input logic [15:0] tmin, input logic [15:0] mask,
                             input logic [15:0] hb);
    write_reg(CFG_NODE_ID, node);
    write_reg(CFG_CLUSTER_SIZE, size);
    write_reg(CFG_TIMEOUT_MIN, tmin);
    write_reg(CFG_RANGE_MASK, mask);
    write_reg(CFG_HB_PERIOD, hb);
  endtask

  task automatic set_idle(input idle_mode_e m);
    case (m)
      IDLE_SEND: begin send_idle_pct = 49; recv_stall_pct = 0; end
      IDLE_RECV: begin send_idle_pct = 0; recv_stall_pct = 49; end
      IDLE_BOTH: begin send_idle_pct = 7; recv_stall_pct = 7; end
      default:   begin send_idle_pct = 0; recv_stall_pct = 0; end
    endcase
  endtask

  // driver: a new word only once the current one is taken
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_word <= pending_words.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < recv_stall_pct);
  end

  // monitor: config and input words feed the predictor, result words are checked
  always @(posedge clk) begin
    if (rst_n) begin
      in_taken <= in_valid && !in_stall;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_NODE_ID:      c_node_id = cfg_data[3:0];
          CFG_CLUSTER_SIZE: c_size = cfg_data[4:0];
          CFG_TIMEOUT_MIN:  c_tmin = cfg_data;
          CFG_RANGE_MASK:   c_mask = cfg_data;
          CFG_HB_PERIOD:    c_hb = cfg_data;
          CFG_RANDOM_SEED:  c_seed = cfg_data;  // recorded only; the design ignores seed writes
          default: ;
        endcase
      end
      if (in_valid && !in_stall) pending_results = {pending_results, election_step(in_word)};
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("unexpected result word: role %0d term %0h", role_o, term_now_o);
        end else begin
          exp_res = pending_results.pop_front();
          if (role_o !== exp_res.role || term_now_o !== exp_res.term_now ||
              reply_term_o !== exp_res.reply_term || granted_o !== exp_res.granted ||
              start_election_o !== exp_res.start_election ||
              send_heartbeats_o !== exp_res.send_heartbeats) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("result mismatch: exp role %0d term %0h reply %0h gr %0b se %0b hb %0b,",
                       exp_res.role, exp_res.term_now, exp_res.reply_term, exp_res.granted,
                       exp_res.start_election, exp_res.send_heartbeats,
                       " got role %0d term %0h reply %0h gr %0b se %0b hb %0b",
                       role_o, term_now_o, reply_term_o, granted_o, start_election_o,
                       send_heartbeats_o);
          end
        end
      end
    end else begin
      in_taken <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int unsigned ph;
    int unsigned tick_pct;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    tick_pct = 50;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: vote rules, term checks, stale replies, win, step down, term wrap
    set_idle(IDLE_NONE);
    load_config(5, 3, 2, 3, 2);
    write_reg(CFG_RANDOM_SEED, 16'h1234);
    queue_word(OP_VOTE_REQ, 0, 3, 0, 0);
    queue_word(OP_VOTE_REQ, 0, 4, 1, 0);
    queue_word(OP_VOTE_REQ, 0, 3, 0, 0);
    queue_word(OP_APPEND, 0, 0, 0, 0);
    queue_word(OP_VOTE_REQ, 5, 9, 0, 0);
    queue_word(OP_APPEND, 2, 0, 0, 0);
    queue_word(OP_VOTE_REQ, 1, 9, 0, 0);
    queue_word(OP_VOTE_REPLY, 5, 0, 1, 5);
    repeat (150) queue_word(OP_TICK, 0, 0, 0, 0);
    queue_word(OP_VOTE_REPLY, 6, 0, 1, 5);
    queue_word(OP_VOTE_REPLY, 6, 0, 0, 6);
    queue_word(OP_VOTE_REPLY, 6, 0, 1, 6);
    repeat (2) queue_word(OP_TICK, 0, 0, 0, 0);
    queue_word(OP_VOTE_REPLY, 6, 0, 1, 6);
    queue_word(OP_VOTE_REPLY, 9, 0, 0, 6);
    queue_word(OP_APPEND, 6, 0, 0, 0);
    queue_word(OP_APPEND, 32'hFFFF_FFFF, 15, 1, 32'hFFFF_FFFF);
    repeat (6) queue_word(OP_TICK, 0, 0, 0, 0);
    queue_word(OP_VOTE_REQ, 32'hFFFF_FFFF, 15, 1, 32'hFFFF_FFFF);
    queue_word(OP_VOTE_REPLY, 0, 0, 0, 0);
    queue_word(OP_APPEND, 0, 0, 0, 0);
    wait_idle();

    for (ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin load_config(5, 3, 3, 7, 4); tick_pct = 50; end
        1: begin load_config(0, 5, 1, 0, 1); tick_pct = 40; end
        2: begin load_config(16'hABCF, 1, 0, 3, 0); tick_pct = 50; end
        3: begin load_config(9, 0, 2, 1, 3); tick_pct = 50; end
        4: begin load_config(3, 16'h00FF, 4, 15, 16'hFFFF); tick_pct = 20; end
        5: begin load_config(12, 16, 6, 15, 2); tick_pct = 25; end
        6: begin
          // tick run with the largest timeout and heartbeat period
          set_idle(IDLE_NONE);
          load_config(7, 2, 16'hFFFF, 16'hFFFF, 16'hFFFF);
          queue_word(OP_APPEND, p_term, 0, 0, 0);
          repeat (20) queue_word(OP_TICK, 0, 0, 0, 0);
          wait_idle();
          queue_word(OP_VOTE_REPLY, p_term, 0, 1, p_term);
          repeat (3) queue_word(OP_TICK, 0, 0, 0, 0);
        end
        default: begin
          load_config(1, 4, 1, 3, 5);
          write_reg(CFG_RANDOM_SEED, 16'h0000);
          write_reg(CFG_SPARE_IDX, 16'hFFFF);
          tick_pct = 45;
        end
      endcase
      if (ph != 6) begin
        set_idle(idle_mode_e'(ph % 4));
        run_random(30, tick_pct);
        wait_idle();  // sender holds off until every result word is back
        set_idle(idle_mode_e'((ph + 1) % 4));
        run_random(30, tick_pct);
      end
      wait_idle();
    end

    set_idle(IDLE_NONE);
    repeat (6) @(posedge clk);
    if (mismatch_cnt == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
